>>> sv/dveq_pkg.sv
// Package for the device event queue table: sizing constants and operation codes.
// No dependencies.
`default_nettype none
package dveq_pkg;
	localparam int MaxDevicesDef = 8;
	localparam int QueueDepthDef = 16;

	typedef enum logic [2:0] {
		OP_REGISTER   = 3'd0,
		OP_UNREGISTER = 3'd1,
		OP_UPDATE     = 3'd2,
		OP_GET_INFO   = 3'd3,
		OP_PUSH       = 3'd4,
		OP_READ       = 3'd5
	} op_t;

	localparam int ReadyBit = 0;
endpackage
`default_nettype wire

>>> sv/device_event_queue_table_core.sv
// Top level of the device event queue table: slot registers and the event word memory.
// Depends on dveq_pkg.
//
// Channel | Direction | Handshake        | Payload
// in      | input     | valid / ready    | op, device_id, claimed_id, dev_type, dev_index,
//         |           |                  | dev_flags, requester, event_data
// out     | output    | out_valid / out_ready | ok, out_id, out_type, out_index,
//         |           |                  | out_flags, out_owner, out_event, wake, live_count
//
// A request goes through the slot lookup and memory access first, then the registered
// memory read, after which the result sits in the output register. A new request is
// taken only when no request is in its read step and the output register is empty or its
// result leaves in the same cycle, so the core cannot take a new request before the last
// one has reached the output register, and a stalled output holds the input off. Reset
// clears the slot table and counters; the event memory needs no clearing.
`default_nettype none
module device_event_queue_table_core #(
	parameter int MAX_DEVICES = dveq_pkg::MaxDevicesDef,
	parameter int QUEUE_DEPTH = dveq_pkg::QueueDepthDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid,
	output logic             ready,
	input  wire logic [2:0]  op,
	input  wire logic [15:0] device_id,
	input  wire logic [15:0] claimed_id,
	input  wire logic [3:0]  dev_type,
	input  wire logic [7:0]  dev_index,
	input  wire logic [7:0]  dev_flags,
	input  wire logic [15:0] requester,
	input  wire logic [31:0] event_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             ok,
	output logic [15:0]      out_id,
	output logic [3:0]       out_type,
	output logic [7:0]       out_index,
	output logic [7:0]       out_flags,
	output logic [15:0]      out_owner,
	output logic [31:0]      out_event,
	output logic             wake,
	output logic [3:0]       live_count
);
	import dveq_pkg::*;

	localparam int SW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(MAX_DEVICES + 1);
	localparam int AW = SW + PW;

	logic [15:0] ident_q  [MAX_DEVICES];
	logic [3:0]  kind_q   [MAX_DEVICES];
	logic [7:0]  number_q [MAX_DEVICES];
	logic [7:0]  bits_q   [MAX_DEVICES];
	logic [15:0] holder_q [MAX_DEVICES];
	logic [PW-1:0] wptr_q [MAX_DEVICES];
	logic [PW-1:0] rptr_q [MAX_DEVICES];
	logic [15:0] next_ident_q;
	logic [CW-1:0] used_q;

	logic [31:0] mem [2**AW];
	logic [31:0] rdata_s2;

	logic busy_s1;
	logic full_q;
	logic ev_s1;

	logic        ok_q, wake_q;
	logic [15:0] id_q, own_q;
	logic [3:0]  type_q;
	logic [7:0]  idx_q, flg_q;
	logic [31:0] ev_q;

	logic          hit, free_found, dup;
	logic [SW-1:0] hs, fs;
	logic          may, rdy, q_full, q_empty;
	logic [PW-1:0] wnext, rnext;
	logic          do_reg, do_unreg, do_upd, do_push, do_read, do_get;
	logic [AW-1:0] maddr;
	logic          acc;

	assign ready = !busy_s1 && (!full_q || out_ready) && !(full_q && busy_s1);
	assign acc   = valid && ready;

	always_comb begin
		hit = 1'b0; hs = '0; free_found = 1'b0; fs = '0; dup = 1'b0;
		for (int i = MAX_DEVICES - 1; i >= 0; i--) begin
			if (ident_q[i] != 16'd0 && ident_q[i] == device_id) begin
				hit = 1'b1; hs = SW'(i);
			end
			if (ident_q[i] == 16'd0) begin
				free_found = 1'b1; fs = SW'(i);
			end
			if (ident_q[i] != 16'd0 && kind_q[i] == dev_type && number_q[i] == dev_index)
				dup = 1'b1;
		end
		may     = holder_q[hs] == 16'd0 || holder_q[hs] == requester;
		rdy     = bits_q[hs][ReadyBit];
		wnext   = (wptr_q[hs] == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q[hs] + PW'(1);
		rnext   = (rptr_q[hs] == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q[hs] + PW'(1);
		q_full  = wnext == rptr_q[hs];
		q_empty = wptr_q[hs] == rptr_q[hs];
		do_reg   = op == OP_REGISTER && used_q < CW'(MAX_DEVICES) && dev_type != 4'd0
			&& next_ident_q != 16'd0 && !dup && free_found;
		do_unreg = op == OP_UNREGISTER && hit && may;
		do_upd   = op == OP_UPDATE && hit && claimed_id == device_id
			&& dev_type == kind_q[hs] && may;
		do_get   = op == OP_GET_INFO && hit;
		do_push  = op == OP_PUSH && hit && rdy && may && !q_full;
		do_read  = op == OP_READ && hit && rdy && !q_empty;
		maddr    = {hs, (op == OP_PUSH) ? wptr_q[hs] : rptr_q[hs]};
	end

	always_ff @(posedge clk) begin
		if (acc && do_push)
			mem[maddr] <= event_data;
		rdata_s2 <= mem[maddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DEVICES; i++) begin
				ident_q[i] <= '0; kind_q[i] <= '0; number_q[i] <= '0;
				bits_q[i] <= '0; holder_q[i] <= '0; wptr_q[i] <= '0; rptr_q[i] <= '0;
			end
			next_ident_q <= 16'd1;
			used_q <= '0;
			busy_s1 <= 1'b0;
			full_q <= 1'b0;
			ev_s1 <= 1'b0;
			ok_q <= 1'b0;
			wake_q <= 1'b0;
			id_q <= '0;
			type_q <= '0;
			idx_q <= '0;
			flg_q <= '0;
			own_q <= '0;
			ev_q <= '0;
		end else begin
			if (full_q && out_ready)
				full_q <= 1'b0;
			if (busy_s1) begin
				busy_s1 <= 1'b0;
				full_q <= 1'b1;
				ev_q <= ev_s1 ? rdata_s2 : 32'd0;
			end
			if (acc) begin
				busy_s1 <= 1'b1;
				ev_s1 <= do_read;
				ok_q <= do_reg | do_unreg | do_upd | do_get | do_push | do_read;
				wake_q <= do_push;
				id_q <= (op == OP_REGISTER) ? (do_reg ? next_ident_q : 16'd0)
					: ((op <= OP_READ) ? device_id : 16'd0);
				type_q <= do_get ? kind_q[hs] : 4'd0;
				idx_q <= do_get ? number_q[hs] : 8'd0;
				flg_q <= do_get ? bits_q[hs] : 8'd0;
				own_q <= do_get ? holder_q[hs] : 16'd0;
				if (do_reg) begin
					ident_q[fs] <= next_ident_q;
					kind_q[fs] <= dev_type;
					number_q[fs] <= dev_index;
					bits_q[fs] <= dev_flags | 8'd1;
					holder_q[fs] <= requester;
					wptr_q[fs] <= '0;
					rptr_q[fs] <= '0;
					next_ident_q <= next_ident_q + 16'd1;
					used_q <= used_q + CW'(1);
				end
				if (do_unreg) begin
					ident_q[hs] <= '0; bits_q[hs] <= '0; holder_q[hs] <= '0;
					wptr_q[hs] <= '0; rptr_q[hs] <= '0;
					if (used_q != '0)
						used_q <= used_q - CW'(1);
				end
				if (do_upd) begin
					bits_q[hs] <= dev_flags;
					number_q[hs] <= dev_index;
				end
				if (do_push)
					wptr_q[hs] <= wnext;
				if (do_read)
					rptr_q[hs] <= rnext;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			live_count <= 4'(used_q + ((do_reg) ? CW'(1) : '0) - ((do_unreg && used_q != '0) ? CW'(1) : '0));
	end

	assign out_valid = full_q;
	assign ok        = ok_q;
	assign out_id    = id_q;
	assign out_type  = type_q;
	assign out_index = idx_q;
	assign out_flags = flg_q;
	assign out_owner = own_q;
	assign out_event = ev_q;
	assign wake      = wake_q;
endmodule
`default_nettype wire

>>> test/tb_device_event_queue_table_core.sv
// Testbench for device_event_queue_table_core: directed and random requests against a
// behavioral model of the slot table and per-device event rings, checked field by field.
// Depends on dveq_pkg and the core.
`default_nettype none
module tb_device_event_queue_table_core;
	timeunit 1ns;
	timeprecision 1ps;
	import dveq_pkg::*;

	localparam int NDEV = 8;
	localparam int QDEP = 16;

	typedef struct packed {
		logic        ok;
		logic [15:0] id;
		logic [3:0]  dtype;
		logic [7:0]  index;
		logic [7:0]  flags;
		logic [15:0] owner;
		logic [31:0] evword;
		logic        wake;
		logic [3:0]  live;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic ready;
	logic [2:0] op = '0;
	logic [15:0] device_id = '0, claimed_id = '0, requester = '0;
	logic [3:0] dev_type = '0;
	logic [7:0] dev_index = '0, dev_flags = '0;
	logic [31:0] event_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic ok, wake;
	logic [15:0] out_id, out_owner;
	logic [3:0] out_type, live_count;
	logic [7:0] out_index, out_flags;
	logic [31:0] out_event;

	device_event_queue_table_core dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [15:0] m_ident [NDEV];
	logic [3:0]  m_kind [NDEV];
	logic [7:0]  m_number [NDEV];
	logic [7:0]  m_bits [NDEV];
	logic [15:0] m_holder [NDEV];
	int          m_wr [NDEV];
	int          m_rd [NDEV];
	logic [31:0] m_ring [NDEV][QDEP];
	logic [15:0] m_next_id;
	int          m_used;

	outcome_t pending_outcomes[$];
	int failures = 0;
	int results_seen = 0;
	int requests_sent = 0;
	bit calm = 1'b0;

	function automatic outcome_t table_step(logic [2:0] o, logic [15:0] dev, logic [15:0] cl,
			logic [3:0] k, logic [7:0] n, logic [7:0] b, logic [15:0] who, logic [31:0] d);
		outcome_t r;
		int s;
		bit refuse;
		bit rdy;
		bit may;
		r = '0;
		s = -1;
		if (o != OP_REGISTER && o <= OP_READ)
			r.id = dev;
		if (o == OP_REGISTER) begin
			refuse = (m_used >= NDEV) || (k == 0) || (m_next_id == 0);
			for (int i = 0; i < NDEV; i++)
				if (m_ident[i] != 0 && m_kind[i] == k && m_number[i] == n)
					refuse = 1'b1;
			if (!refuse) begin
				for (int i = NDEV - 1; i >= 0; i--)
					if (m_ident[i] == 0)
						s = i;
			end
			if (!refuse && s >= 0) begin
				m_ident[s] = m_next_id;
				m_kind[s] = k;
				m_number[s] = n;
				m_bits[s] = b | 8'd1;
				m_holder[s] = who;
				m_wr[s] = 0;
				m_rd[s] = 0;
				r.id = m_next_id;
				r.ok = 1'b1;
				m_next_id = m_next_id + 16'd1;
				m_used++;
			end
		end else if (o <= OP_READ) begin
			if (dev != 0)
				for (int i = NDEV - 1; i >= 0; i--)
					if (m_ident[i] == dev)
						s = i;
			if (s >= 0) begin
				rdy = m_bits[s][ReadyBit];
				may = (m_holder[s] == 0) || (m_holder[s] == who);
				case (o)
					OP_UNREGISTER: begin
						if (may) begin
							m_ident[s] = 0;
							m_bits[s] = 0;
							m_holder[s] = 0;
							m_wr[s] = 0;
							m_rd[s] = 0;
							if (m_used > 0)
								m_used--;
							r.ok = 1'b1;
						end
					end
					OP_UPDATE: begin
						if (cl == dev && k == m_kind[s] && may) begin
							m_bits[s] = b;
							m_number[s] = n;
							r.ok = 1'b1;
						end
					end
					OP_GET_INFO: begin
						r.dtype = m_kind[s];
						r.index = m_number[s];
						r.flags = m_bits[s];
						r.owner = m_holder[s];
						r.ok = 1'b1;
					end
					OP_PUSH: begin
						if (rdy && may && ((m_wr[s] + 1) % QDEP) != m_rd[s]) begin
							m_ring[s][m_wr[s]] = d;
							m_wr[s] = (m_wr[s] + 1) % QDEP;
							r.ok = 1'b1;
							r.wake = 1'b1;
						end
					end
					default: begin
						if (rdy && m_wr[s] != m_rd[s]) begin
							r.evword = m_ring[s][m_rd[s]];
							m_rd[s] = (m_rd[s] + 1) % QDEP;
							r.ok = 1'b1;
						end
					end
				endcase
			end
		end
		r.live = m_used[3:0];
		return r;
	endfunction

	task automatic send_request(logic [2:0] o, logic [15:0] dev, logic [15:0] cl, logic [3:0] k,
			logic [7:0] n, logic [7:0] b, logic [15:0] who, logic [31:0] d);
		while (!calm && $urandom_range(99) < 35) begin
			valid <= 1'b0;
			@(negedge clk);
		end
		op <= o;
		device_id <= dev;
		claimed_id <= cl;
		dev_type <= k;
		dev_index <= n;
		dev_flags <= b;
		requester <= who;
		event_data <= d;
		valid <= 1'b1;
		@(posedge clk);
		while (!ready)
			@(posedge clk);
		pending_outcomes.push_back(table_step(o, dev, cl, k, n, b, who, d));
		requests_sent++;
		@(negedge clk);
	endtask

	always @(negedge clk)
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
			end else begin
				want = pending_outcomes.pop_front();
				if (ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, ok); failures++;
				end
				if (out_id !== want.id) begin
					$error("out_id: expected %0d, got %0d", want.id, out_id); failures++;
				end
				if (out_type !== want.dtype) begin
					$error("out_type: expected %0d, got %0d", want.dtype, out_type); failures++;
				end
				if (out_index !== want.index) begin
					$error("out_index: expected %0d, got %0d", want.index, out_index);
					failures++;
				end
				if (out_flags !== want.flags) begin
					$error("out_flags: expected %0h, got %0h", want.flags, out_flags);
					failures++;
				end
				if (out_owner !== want.owner) begin
					$error("out_owner: expected %0d, got %0d", want.owner, out_owner);
					failures++;
				end
				if (out_event !== want.evword) begin
					$error("out_event: expected %0h, got %0h", want.evword, out_event);
					failures++;
				end
				if (wake !== want.wake) begin
					$error("wake: expected %0d, got %0d", want.wake, wake); failures++;
				end
				if (live_count !== want.live) begin
					$error("live_count: expected %0d, got %0d", want.live, live_count);
					failures++;
				end
			end
		end
	end

	function automatic logic [15:0] live_id();
		logic [15:0] ids[$];
		for (int i = 0; i < NDEV; i++)
			if (m_ident[i] != 0)
				ids.push_back(m_ident[i]);
		if (ids.size() == 0)
			return m_next_id;
		return ids[$urandom_range(ids.size() - 1)];
	endfunction

	function automatic int slot_of(logic [15:0] id);
		for (int i = 0; i < NDEV; i++)
			if (m_ident[i] == id && id != 0)
				return i;
		return 0;
	endfunction

	task automatic test_registration();
		send_request(OP_REGISTER, 0, 0, 0, 8'd1, 0, 0, 0);
		send_request(OP_REGISTER, 16'hFFFF, 0, 4'd15, 8'd255, 8'hFE, 16'hFFFF, 32'hFFFFFFFF);
		send_request(OP_REGISTER, 0, 0, 4'd15, 8'd255, 0, 0, 0);
		for (int i = 0; i < 8; i++)
			send_request(OP_REGISTER, 0, 0, 4'd1, 8'(i), 8'h00, 16'(i & 1), 0);
		send_request(OP_GET_INFO, 16'd1, 0, 0, 0, 0, 0, 0);
		send_request(OP_GET_INFO, 16'd0, 0, 0, 0, 0, 0, 0);
		send_request(OP_GET_INFO, 16'hFFFF, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_ownership_and_update();
		send_request(OP_UNREGISTER, 16'd1, 0, 0, 0, 0, 16'd5, 0);
		send_request(OP_UNREGISTER, 16'd1, 0, 0, 0, 0, 16'hFFFF, 0);
		send_request(OP_UPDATE, 16'd2, 16'd3, 4'd1, 8'd9, 8'h00, 0, 0);
		send_request(OP_UPDATE, 16'd2, 16'd2, 4'd2, 8'd9, 8'h00, 0, 0);
		send_request(OP_UPDATE, 16'd2, 16'd2, 4'd1, 8'd9, 8'h00, 0, 0);
		send_request(OP_PUSH, 16'd2, 0, 0, 0, 0, 0, 32'h1234);
		send_request(OP_READ, 16'd2, 0, 0, 0, 0, 0, 0);
		send_request(OP_REGISTER, 0, 0, 4'd3, 8'd3, 8'h80, 16'd7, 0);
		send_request(OP_READ, 16'd3, 0, 0, 0, 0, 0, 0);
		send_request(3'd6, 16'd3, 0, 0, 0, 0, 0, 0);
		send_request(3'd7, 16'd3, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_queue_fill();
		for (int i = 0; i < QDEP; i++)
			send_request(OP_PUSH, 16'd3, 0, 0, 0, 0, 16'd1, $urandom());
		for (int i = 0; i < QDEP; i++)
			send_request(OP_READ, 16'd3, 0, 0, 0, 0, 16'd9, 0);
	endtask

	task automatic test_random(int count);
		logic [15:0] id, who;
		int pick;
		for (int n = 0; n < count; n++) begin
			calm = (n >= count / 3) && (n < count / 2);
			id = ($urandom_range(9) == 0) ? 16'($urandom()) : live_id();
			who = $urandom_range(2) == 0 ? 16'($urandom()) : m_holder[slot_of(id)];
			pick = $urandom_range(99);
			if (pick < 14)
				send_request(OP_REGISTER, 16'($urandom()), 0, 4'($urandom_range(3)),
					8'($urandom_range(5)), 8'($urandom()), 16'($urandom_range(3)), 0);
			else if (pick < 20)
				send_request(OP_UNREGISTER, id, 0, 0, 0, 0, who, 0);
			else if (pick < 30)
				send_request(OP_UPDATE, id, $urandom_range(4) == 0 ? 16'($urandom()) : id,
					$urandom_range(4) == 0 ? 4'($urandom()) : m_kind[slot_of(id)],
					8'($urandom()), 8'($urandom()) | 8'($urandom_range(3) != 0),
					who, 0);
			else if (pick < 38)
				send_request(OP_GET_INFO, id, 16'($urandom()), 4'($urandom()), 8'($urandom()),
					8'($urandom()), who, $urandom());
			else if (pick < 70)
				send_request(OP_PUSH, id, 0, 0, 0, 0, who, $urandom());
			else if (pick < 97)
				send_request(OP_READ, id, 0, 0, 0, 0, who, 0);
			else
				send_request(3'($urandom_range(6, 7)), id, 0, 0, 0, 0, who, 0);
		end
		calm = 1'b0;
	endtask

	initial begin
		foreach (m_ident[i]) begin
			m_ident[i] = 0; m_kind[i] = 0; m_number[i] = 0; m_bits[i] = 0;
			m_holder[i] = 0; m_wr[i] = 0; m_rd[i] = 0;
		end
		m_next_id = 16'd1;
		m_used = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_registration();
		test_ownership_and_update();
		test_queue_fill();
		test_random(540);
		valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d requests covering all operations, ownership checks and full queues;",
			requests_sent);
		$display("checked %0d results.", results_seen);
		if (failures == 0 && pending_outcomes.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#60ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
sv/dveq_pkg.sv
sv/device_event_queue_table_core.sv
test/tb_device_event_queue_table_core.sv
